>>> src/epe_pkg.sv
// shared constants, types and GF(2^8) arithmetic for the erasure parity encoder
package epe_pkg;

    // number of parity cells in the chain
    localparam int MAX_PARITY = 16;
    // byte and field widths
    localparam int BYTE_W     = 8;
    localparam int ROW_OUT_W  = 4;
    localparam int DSC_W      = 8;
    localparam int PSC_W      = 5;
    // counters over the parity rows
    localparam int ROW_W      = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int CNT_W      = $clog2(MAX_PARITY + 1);
    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SHARD_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 1'b1;
    // register reset values
    localparam logic [DSC_W-1:0] DSC_RESET = 8'd4;
    localparam logic [PSC_W-1:0] PSC_RESET = 5'd2;
    // field polynomial low byte and top bit
    localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1d;
    localparam logic [BYTE_W-1:0] GF_TOP_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0] GF_ONE      = 8'h01;

    // control handed from the top level to every cell
    typedef struct packed {
        logic accept;   // an item is taken this cycle
        logic col_end;  // the item closes its column
        logic shift;    // a parity item is taken at the output
    } cell_ctl_t;

    // multiply by alpha
    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] s;
        s = {v[BYTE_W-2:0], 1'b0};
        return ((v & GF_TOP_BIT) != '0) ? (s ^ GF_POLY_LOW) : s;
    endfunction

    // shift and add product
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] p;
        logic [BYTE_W-1:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                p = p ^ x;
            end
            x = gf_xtime(x);
        end
        return p;
    endfunction

endpackage

>>> src/erasure_parity_encoder_gf256.sv
// top level of the GF(2^8) erasure parity encoder
// Usage:
//   s_ channel: one data byte per item, column by column, shards 0 to k-1.
//   m_ channel: m parity items per column, row in m_tuser, byte in m_tdata,
//   m_tlast on the final row of the column.
//   cfg channel: index 0 writes k (data shards), index 1 writes m (parity
//   rows); write only while no column is open and no parity item pending.
// Throughput: one data byte per cycle. Every parity row has its own cell,
// so all rows update together. The byte that closes a column is held off
// while the previous column's parity items are still in the output chain,
// up to the cycle in which the last of them is taken; the chain drains one
// item per cycle while the receiver takes them.
// Parity row 0 is offered in the cycle after the closing byte is taken.
// Reset: accumulators and shard counter clear, k = 4, m = 2, no output.
// Receiver stall: the output chain holds its items; data bytes that do not
// close a column are still taken, the closing byte waits for the chain.
module erasure_parity_encoder_gf256 (
    input  logic                              aclk,
    input  logic                              aresetn,
    // data input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    // parity output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] parity_byte
    output logic [3:0]                        m_tuser,   // [3:0] row index
    output logic                              m_tlast,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [epe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data
);

    logic [epe_pkg::DSC_W-1:0] dsc_reg, dsc_next;
    logic [epe_pkg::PSC_W-1:0] psc_reg, psc_next;
    logic [epe_pkg::DSC_W-1:0] shard_reg, shard_next;
    logic [epe_pkg::CNT_W-1:0] pend_reg, pend_next;
    logic [epe_pkg::ROW_W-1:0] row_reg, row_next;
    logic [epe_pkg::DSC_W:0]   shard_inc;
    logic [epe_pkg::DSC_W:0]   k_eff;
    logic [epe_pkg::CNT_W-1:0] m_eff;
    logic                      col_end;
    logic                      s_acc;
    logic                      m_acc;
    epe_pkg::cell_ctl_t        ctl;

    logic [epe_pkg::BYTE_W-1:0] step_w [epe_pkg::MAX_PARITY+1];
    logic [epe_pkg::BYTE_W-1:0] snap_w [epe_pkg::MAX_PARITY+1];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        dsc_next = dsc_reg;
        psc_next = psc_reg;
        if (cfg_valid) begin
            case (cfg_index)
                epe_pkg::REG_SHARD_COUNT: dsc_next = cfg_data;
                epe_pkg::REG_ROW_COUNT:   psc_next = cfg_data[epe_pkg::PSC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective shard and row counts
    assign k_eff = (dsc_reg == '0) ? (epe_pkg::DSC_W+1)'(1) : {1'b0, dsc_reg};
    always_comb begin
        if (psc_reg == '0) begin
            m_eff = epe_pkg::CNT_W'(1);
        end else if (int'(psc_reg) > epe_pkg::MAX_PARITY) begin
            m_eff = epe_pkg::CNT_W'(epe_pkg::MAX_PARITY);
        end else begin
            m_eff = epe_pkg::CNT_W'(psc_reg);
        end
    end

    // column end detection and input handshake, the last pending item may leave alongside
    assign shard_inc = {1'b0, shard_reg} + (epe_pkg::DSC_W+1)'(1);
    assign col_end   = (shard_inc >= k_eff);
    assign s_tready  = (pend_reg == '0) || !col_end ||
                       ((pend_reg == epe_pkg::CNT_W'(1)) && m_tready);
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;

    // shard counter, pending count and output row
    always_comb begin
        shard_next = shard_reg;
        pend_next  = pend_reg;
        row_next   = row_reg;
        if (m_acc) begin
            pend_next = pend_reg - epe_pkg::CNT_W'(1);
            row_next  = row_reg + epe_pkg::ROW_W'(1);
        end
        if (s_acc) begin
            if (col_end) begin
                shard_next = '0;
                pend_next  = m_eff;
                row_next   = '0;
            end else begin
                shard_next = shard_inc[epe_pkg::DSC_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dsc_reg   <= epe_pkg::DSC_RESET;
            psc_reg   <= epe_pkg::PSC_RESET;
            shard_reg <= '0;
            pend_reg  <= '0;
            row_reg   <= '0;
        end else begin
            dsc_reg   <= dsc_next;
            psc_reg   <= psc_next;
            shard_reg <= shard_next;
            pend_reg  <= pend_next;
            row_reg   <= row_next;
        end
    end

    // chain of parity cells
    assign ctl.accept  = s_acc;
    assign ctl.col_end = col_end;
    assign ctl.shift   = m_acc;
    assign step_w[0]   = epe_pkg::GF_ONE;
    assign snap_w[epe_pkg::MAX_PARITY] = '0;

    for (genvar r = 0; r < epe_pkg::MAX_PARITY; r++) begin : g_cell
        epe_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .data_byte (s_tdata),
            .step_in   (step_w[r]),
            .step_out  (step_w[r+1]),
            .snap_in   (snap_w[r+1]),
            .snap_out  (snap_w[r])
        );
    end

    // output channel
    assign m_tvalid = (pend_reg != '0);
    assign m_tdata  = snap_w[0];
    assign m_tuser  = 4'(row_reg);
    assign m_tlast  = (pend_reg == epe_pkg::CNT_W'(1));

    // pending count never exceeds the number of cells
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(pend_reg) <= epe_pkg::MAX_PARITY)
        else $error("pending parity count out of range");

    // a closing byte starts its column's output at row zero
    a_col_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && col_end) |=> (m_tvalid && row_reg == '0))
        else $error("column output did not start at row zero");

    // a closing byte is only taken when the output chain is empty or emptying
    a_chain_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && col_end) |->
            ((pend_reg == '0) || (pend_reg == epe_pkg::CNT_W'(1) && m_acc)))
        else $error("column closed while parity items pending");

    // rows advance by one per output item within a column
    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && !m_tlast) |=> (row_reg == $past(row_reg) + epe_pkg::ROW_W'(1)))
        else $error("parity row did not advance");

endmodule

>>> src/epe_cell.sv
// one parity cell: accumulator, running coefficient and output snapshot stage
module epe_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  epe_pkg::cell_ctl_t            ctl,
    input  logic [epe_pkg::BYTE_W-1:0]    data_byte,
    input  logic [epe_pkg::BYTE_W-1:0]    step_in,   // alpha^r for this cell
    output logic [epe_pkg::BYTE_W-1:0]    step_out,  // alpha^(r+1) for the next cell
    input  logic [epe_pkg::BYTE_W-1:0]    snap_in,   // snapshot of the next cell
    output logic [epe_pkg::BYTE_W-1:0]    snap_out
);

    logic [epe_pkg::BYTE_W-1:0] acc_reg, acc_next;
    logic [epe_pkg::BYTE_W-1:0] coef_reg, coef_next;
    logic [epe_pkg::BYTE_W-1:0] snap_reg, snap_next;
    logic [epe_pkg::BYTE_W-1:0] term;
    logic [epe_pkg::BYTE_W-1:0] acc_sum;

    // step constant for the neighbour
    assign step_out = epe_pkg::gf_xtime(step_in);

    // contribution of this byte, coefficient alpha^(r*j)
    assign term    = epe_pkg::gf_mul(data_byte, coef_reg);
    assign acc_sum = acc_reg ^ term;

    // accumulator and coefficient update
    always_comb begin
        acc_next  = acc_reg;
        coef_next = coef_reg;
        if (ctl.accept) begin
            if (ctl.col_end) begin
                acc_next  = '0;
                coef_next = epe_pkg::GF_ONE;
            end else begin
                acc_next  = acc_sum;
                coef_next = epe_pkg::gf_mul(coef_reg, step_in);
            end
        end
    end

    // snapshot stage: load at column end, shift towards cell zero on output
    always_comb begin
        snap_next = snap_reg;
        if (ctl.accept && ctl.col_end) begin
            snap_next = acc_sum;
        end else if (ctl.shift) begin
            snap_next = snap_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            coef_reg <= epe_pkg::GF_ONE;
        end else begin
            acc_reg  <= acc_next;
            coef_reg <= coef_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

    assign snap_out = snap_reg;

endmodule

>>> verif/epe_parity_checker.sv
// channel monitor, parity prediction and comparison for the erasure parity encoder
module epe_parity_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // [7:0] data_byte
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,    // [7:0] parity_byte
    input  logic [3:0]                    m_tuser,    // [3:0] row index
    input  logic                          m_tlast,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [epe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // one parity item as it should leave the block
    typedef struct packed {
        logic [epe_pkg::ROW_OUT_W-1:0] row;
        logic [epe_pkg::BYTE_W-1:0]    value;
        logic                          last;
    } parity_item_t;

    parity_item_t               parity_due[$];
    logic [epe_pkg::BYTE_W-1:0] alpha_pow [0:254];
    int                         alpha_log [0:255];
    logic [epe_pkg::BYTE_W-1:0] row_sum   [0:epe_pkg::MAX_PARITY-1];
    logic [epe_pkg::DSC_W-1:0]  shard_pos;
    logic [epe_pkg::DSC_W-1:0]  k_setting;
    logic [epe_pkg::PSC_W-1:0]  m_setting;
    int                         faults = 0;

    assign mismatches = faults;

    // power and log tables of alpha over the 0x11d field
    initial begin : build_tables
        logic [epe_pkg::BYTE_W-1:0] v;
        v = epe_pkg::GF_ONE;
        for (int i = 0; i < 255; i++) begin
            alpha_pow[i] = v;
            alpha_log[v] = i;
            v = {v[epe_pkg::BYTE_W-2:0], 1'b0} ^
                (v[epe_pkg::BYTE_W-1] ? epe_pkg::GF_POLY_LOW : 8'h00);
        end
        alpha_log[0] = 0;
    end

    // field product through the log tables
    function automatic logic [epe_pkg::BYTE_W-1:0] field_product(
        input logic [epe_pkg::BYTE_W-1:0] a,
        input logic [epe_pkg::BYTE_W-1:0] b);
        if (a == 0 || b == 0) begin
            return 8'h00;
        end
        return alpha_pow[(alpha_log[a] + alpha_log[b]) % 255];
    endfunction

    // fold one data byte into every row and close the column when due
    task automatic fold_data_byte(input logic [epe_pkg::BYTE_W-1:0] d);
        int j;
        int k_eff;
        int m_eff;
        parity_item_t item;
        j = shard_pos;
        k_eff = (k_setting == 0) ? 1 : k_setting;
        m_eff = (m_setting == 0) ? 1 : m_setting;
        if (m_eff > epe_pkg::MAX_PARITY) begin
            m_eff = epe_pkg::MAX_PARITY;
        end
        for (int r = 0; r < epe_pkg::MAX_PARITY; r++) begin
            row_sum[r] ^= field_product(alpha_pow[(r * j) % 255], d);
        end
        if (j + 1 < k_eff) begin
            shard_pos = epe_pkg::DSC_W'(j + 1);
        end else begin
            for (int r = 0; r < m_eff; r++) begin
                item.row   = epe_pkg::ROW_OUT_W'(r);
                item.value = row_sum[r];
                item.last  = (r + 1 == m_eff);
                parity_due.push_back(item);
            end
            for (int r = 0; r < epe_pkg::MAX_PARITY; r++) begin
                row_sum[r] = 8'h00;
            end
            shard_pos = '0;
        end
    endtask

    // per edge: compare outgoing parity, then apply register writes and data
    always @(posedge aclk) begin : monitor
        parity_item_t want;
        if (!aresetn) begin
            parity_due.delete();
            for (int r = 0; r < epe_pkg::MAX_PARITY; r++) begin
                row_sum[r] = 8'h00;
            end
            shard_pos = '0;
            k_setting = epe_pkg::DSC_RESET;
            m_setting = epe_pkg::PSC_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (parity_due.size() == 0) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("unexpected parity item: row %0d byte %02h last %0b",
                                 m_tuser, m_tdata, m_tlast);
                    end
                end else begin
                    want = parity_due.pop_front();
                    if (m_tuser !== want.row || m_tdata !== want.value ||
                        m_tlast !== want.last) begin
                        faults++;
                        if (faults <= 10) begin
                            $display({"parity mismatch: expected row %0d byte %02h",
                                      " last %0b, got row %0d byte %02h last %0b"},
                                     want.row, want.value, want.last,
                                     m_tuser, m_tdata, m_tlast);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == epe_pkg::REG_SHARD_COUNT) begin
                    k_setting = cfg_data;
                end else if (cfg_index == epe_pkg::REG_ROW_COUNT) begin
                    m_setting = cfg_data[epe_pkg::PSC_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                fold_data_byte(s_tdata);
            end
        end
        outstanding <= parity_due.size();
    end

endmodule

>>> verif/testbench.sv
// stimulus, clock, reset and verdict for the erasure parity encoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int SMALL_BUDGET = 155;

    // receiver stall patterns
    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = 8'h00;   // [7:0] data_byte
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [7:0]                    m_tdata;             // [7:0] parity_byte
    logic [3:0]                    m_tuser;             // [3:0] row index
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [epe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]                    cfg_data  = 8'h00;

    int          mismatches;
    int          outstanding;
    int          burst_left  = 0;
    int          sent_items  = 0;
    logic        hold_go     = 1'b0;
    int unsigned cycle_count = 0;

    erasure_parity_encoder_gf256 u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    epe_parity_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: segments of random stall patterns, one long hold-off on request
    initial begin : receiver
        rx_mode_t mode;
        int       seg_len;
        bit       held;
        held = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_go && !held) begin
                held = 1'b1;
                repeat (LONG_HOLD) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            mode    = rx_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(4, 48);
            repeat (seg_len) begin
                case (mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ~m_tready;
                endcase
                @(posedge aclk);
            end
        end
    end

    // offer one data item, with bursts and gaps, and wait for its acceptance
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    // stop offering and let every parity item drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register write through the config channel
    task automatic write_reg(input logic [epe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // new shard counts once the block is quiet
    task automatic set_shards(input logic [7:0] kv, input logic [7:0] mv);
        wait_idle();
        write_reg(epe_pkg::REG_SHARD_COUNT, kv);
        @(posedge aclk);
        write_reg(epe_pkg::REG_ROW_COUNT, mv);
    endtask

    // whole columns of random bytes, sometimes with a trailing partial column
    task automatic run_columns(input logic [7:0] kv, input int cols, input bit ragged);
        int keff;
        int total;
        keff  = (kv == 0) ? 1 : kv;
        total = cols * keff;
        if (ragged && keff > 1) begin
            total += $urandom_range(1, keff - 1);
        end
        repeat (total) send_byte(8'($urandom_range(0, 255)));
    endtask

    // stimulus and verdict
    initial begin : stimulus
        logic [7:0] kv;
        logic [7:0] mv;
        int         mfield;
        int         cols;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset counts, extreme bytes
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'h01);
        // zero counts act as one
        set_shards(8'd0, 8'd0);
        send_byte(8'hff);
        send_byte(8'h00);
        // single shard, full parity
        set_shards(8'd1, 8'd16);
        send_byte(8'ha5);
        send_byte(8'h5a);
        // parity count above the maximum, upper data bits ignored
        set_shards(8'd2, 8'h31);
        send_byte(8'h00);
        send_byte(8'hff);
        // shard count lowered while a column is open
        set_shards(8'd6, 8'd3);
        send_byte(8'h3c);
        send_byte(8'hc3);
        send_byte(8'h7e);
        wait_idle();
        write_reg(epe_pkg::REG_SHARD_COUNT, 8'd2);
        send_byte(8'h81);
        set_shards(8'd3, 8'h14);
        send_byte(8'h12);
        send_byte(8'hed);
        send_byte(8'h96);

        // one byte per column with full parity while the receiver holds off
        set_shards(8'd1, 8'd16);
        hold_go <= 1'b1;
        run_columns(8'd1, 40, 1'b0);

        // small random settings
        while (sent_items < SMALL_BUDGET) begin
            case ($urandom_range(0, 9))
                0:       kv = 8'd0;
                1:       kv = 8'($urandom_range(11, 24));
                default: kv = 8'($urandom_range(1, 10));
            endcase
            case ($urandom_range(0, 7))
                0:       mfield = 0;
                1:       mfield = $urandom_range(17, 31);
                default: mfield = $urandom_range(1, 16);
            endcase
            mv   = 8'(($urandom_range(0, 7) << 5) | mfield);
            cols = (kv > 10) ? 1 : $urandom_range(1, 5);
            set_shards(kv, mv);
            run_columns(kv, cols, ($urandom_range(0, 4) == 0));
        end

        // largest shard count, beyond the usual range
        set_shards(8'hff, 8'hff);
        run_columns(8'hff, 1, 1'b0);

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
